FILE: sv/bcdrtc_pkg.sv
package bcdrtc_pkg;

    localparam logic [7:0]  HourModeMask = 8'h40;
    localparam logic [7:0]  CenturyMask  = 8'h80;
    localparam logic [11:0] BaseYear     = 12'd2000;
    localparam logic [6:0]  MaxSecond    = 7'd59;
    localparam logic [6:0]  MaxMinute    = 7'd59;
    localparam logic [5:0]  MaxHour      = 6'd23;
    localparam logic [4:0]  MaxMonth     = 5'd12;

    // stage 1 -> stage 2: raw decoded values, format errors folded into fail
    typedef struct packed {
        logic       fail;
        logic [6:0] sec;
        logic [6:0] min;
        logic [5:0] hr;
        logic [5:0] dy;
        logic [4:0] mo;
        logic [6:0] yv;
        logic       lost;
    } t_s1;

    // stage 2 -> stage 3: range-checked values plus month length
    typedef struct packed {
        logic       ok;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
        logic [4:0] dy;
        logic [3:0] mo;
        logic [6:0] yv;
        logic [4:0] mlen;
        logic       lost;
    } t_s2;

    typedef struct packed {
        logic        time_valid;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        osc_stopped;
    } t_res;

    function automatic logic bcd_ok(input logic [7:0] v);
        return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
    endfunction

    // tens * 10 + units, tens * 10 built as tens * 8 + tens * 2
    function automatic logic [6:0] bcd_bin(input logic [7:0] v);
        logic [7:0] s;
        s = {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
        return s[6:0];
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] n;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
            4'd2:                                      n = leap ? 5'd29 : 5'd28;
            default:                                   n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: sv/bcdrtc_unpack.sv
module bcdrtc_unpack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_raw_seconds,
    input  logic [7:0]        i_raw_minutes,
    input  logic [7:0]        i_raw_hours,
    input  logic [7:0]        i_raw_weekday,
    input  logic [7:0]        i_raw_date,
    input  logic [7:0]        i_raw_month,
    input  logic [7:0]        i_raw_year,
    input  logic [7:0]        i_status_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output bcdrtc_pkg::t_s1   o_data
);

    logic            r_valid;
    bcdrtc_pkg::t_s1 r_data;
    bcdrtc_pkg::t_s1 n_data;
    logic [7:0]      s_b, m_b, h_b, d_b, mo_b;
    logic [6:0]      h_bin, d_bin, mo_bin;

    always_comb begin
        s_b  = {1'b0, i_raw_seconds[6:0]};
        m_b  = {1'b0, i_raw_minutes[6:0]};
        h_b  = {2'b00, i_raw_hours[5:0]};
        d_b  = {2'b00, i_raw_date[5:0]};
        mo_b = {3'b000, i_raw_month[4:0]};
        h_bin  = bcdrtc_pkg::bcd_bin(h_b);
        d_bin  = bcdrtc_pkg::bcd_bin(d_b);
        mo_bin = bcdrtc_pkg::bcd_bin(mo_b);
        n_data.fail = ((i_raw_hours & bcdrtc_pkg::HourModeMask) != 8'h00)
                    || ((i_raw_month & bcdrtc_pkg::CenturyMask) != 8'h00)
                    || !bcdrtc_pkg::bcd_ok(s_b) || !bcdrtc_pkg::bcd_ok(m_b)
                    || !bcdrtc_pkg::bcd_ok(h_b) || !bcdrtc_pkg::bcd_ok(d_b)
                    || !bcdrtc_pkg::bcd_ok(mo_b) || !bcdrtc_pkg::bcd_ok(i_raw_year)
                    || (i_raw_weekday[2:0] == 3'd0);
        n_data.sec  = bcdrtc_pkg::bcd_bin(s_b);
        n_data.min  = bcdrtc_pkg::bcd_bin(m_b);
        n_data.hr   = h_bin[5:0];
        n_data.dy   = d_bin[5:0];
        n_data.mo   = mo_bin[4:0];
        n_data.yv   = bcdrtc_pkg::bcd_bin(i_raw_year);
        n_data.lost = i_status_byte[7];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/bcdrtc_range.sv
module bcdrtc_range (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bcdrtc_pkg::t_s1   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output bcdrtc_pkg::t_s2   o_data
);

    logic            r_valid;
    bcdrtc_pkg::t_s2 r_data;
    bcdrtc_pkg::t_s2 n_data;
    logic            leap;

    // years 2000..2099: only multiples of four are leap, 2000 included
    assign leap = (i_data.yv[1:0] == 2'b00);

    always_comb begin
        n_data.ok   = !i_data.fail
                    && (i_data.sec <= bcdrtc_pkg::MaxSecond)
                    && (i_data.min <= bcdrtc_pkg::MaxMinute)
                    && (i_data.hr <= bcdrtc_pkg::MaxHour)
                    && (i_data.mo != 5'd0) && (i_data.mo <= bcdrtc_pkg::MaxMonth)
                    && (i_data.dy != 6'd0) && (i_data.dy[5] == 1'b0);
        n_data.sec  = i_data.sec[5:0];
        n_data.min  = i_data.min[5:0];
        n_data.hr   = i_data.hr[4:0];
        n_data.dy   = i_data.dy[4:0];
        n_data.mo   = i_data.mo[3:0];
        n_data.yv   = i_data.yv;
        n_data.mlen = bcdrtc_pkg::month_len(i_data.mo[3:0], leap);
        n_data.lost = i_data.lost;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/bcdrtc_fit.sv
module bcdrtc_fit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bcdrtc_pkg::t_s2   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output bcdrtc_pkg::t_res  o_data
);

    logic             r_valid;
    bcdrtc_pkg::t_res r_data;
    bcdrtc_pkg::t_res n_data;
    logic             ok;

    assign ok = i_data.ok && (i_data.dy <= i_data.mlen);

    always_comb begin
        n_data.time_valid  = ok;
        n_data.year        = ok ? bcdrtc_pkg::BaseYear + {5'b00000, i_data.yv} : 12'd0;
        n_data.month       = ok ? i_data.mo  : 4'd0;
        n_data.day         = ok ? i_data.dy  : 5'd0;
        n_data.hour        = ok ? i_data.hr  : 5'd0;
        n_data.minute      = ok ? i_data.min : 6'd0;
        n_data.second      = ok ? i_data.sec : 6'd0;
        n_data.osc_stopped = i_data.lost;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/bcd_rtc_time_validate_decode.sv
// pipeline: 3 register stages, an item is registered in unpack, then range, then fit
// throughput: one item per cycle while the result side takes items, set by the register pipeline
// each stage holds its item while the downstream stage is full and stalled
// reset (synchronous, active low) clears the stage valid bits; data regs keep contents
module bcd_rtc_time_validate_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_raw_seconds,
    input  logic [7:0]  i_raw_minutes,
    input  logic [7:0]  i_raw_hours,
    input  logic [7:0]  i_raw_weekday,
    input  logic [7:0]  i_raw_date,
    input  logic [7:0]  i_raw_month,
    input  logic [7:0]  i_raw_year,
    input  logic [7:0]  i_status_byte,
    // result item channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_time_valid,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic        o_osc_stopped
);

    // stage handshakes: ready ripples back, a stage takes a new item when
    // it is empty or its item moves on in the same cycle
    logic             s1_valid, s1_ready;
    logic             s2_valid, s2_ready;
    bcdrtc_pkg::t_s1  s1_data;
    bcdrtc_pkg::t_s2  s2_data;
    bcdrtc_pkg::t_res res;

    // stage 1: mode and century bits, bcd digit checks, weekday, digit -> binary
    bcdrtc_unpack u_unpack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_raw_seconds (i_raw_seconds),
        .i_raw_minutes (i_raw_minutes),
        .i_raw_hours   (i_raw_hours),
        .i_raw_weekday (i_raw_weekday),
        .i_raw_date    (i_raw_date),
        .i_raw_month   (i_raw_month),
        .i_raw_year    (i_raw_year),
        .i_status_byte (i_status_byte),
        .o_valid       (s1_valid),
        .i_ready       (s1_ready),
        .o_data        (s1_data)
    );

    // stage 2: field range checks and month length lookup with leap rule
    bcdrtc_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // stage 3: day against month length, full year, zeroing of rejected time
    bcdrtc_fit u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (res)
    );

    assign o_time_valid  = res.time_valid;
    assign o_year        = res.year;
    assign o_month       = res.month;
    assign o_day         = res.day;
    assign o_hour        = res.hour;
    assign o_minute      = res.minute;
    assign o_second      = res.second;
    assign o_osc_stopped = res.osc_stopped;

endmodule

FILE: sv/bcdrtc_check.sv
module bcdrtc_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_time_valid,
    input logic [11:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second,
    input logic        o_osc_stopped
);

    a_valid_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_time_valid |-> o_year >= 12'd2000 && o_year <= 12'd2099)
        else $error("decoded year out of range");

    a_valid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_time_valid |-> o_month != 4'd0 && o_month <= 4'd12
            && o_day != 5'd0 && o_hour <= 5'd23 && o_minute <= 6'd59
            && o_second <= 6'd59)
        else $error("decoded field out of range");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_time_valid |-> o_year == 12'd0 && o_month == 4'd0
            && o_day == 5'd0 && o_hour == 5'd0 && o_minute == 6'd0
            && o_second == 6'd0)
        else $error("rejected time has nonzero fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_time_valid) && $stable(o_year)
            && $stable(o_month) && $stable(o_day) && $stable(o_hour)
            && $stable(o_minute) && $stable(o_second) && $stable(o_osc_stopped))
        else $error("stalled result item changed");

endmodule

bind bcd_rtc_time_validate_decode bcdrtc_check u_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_time_valid  (o_time_valid),
    .o_year        (o_year),
    .o_month       (o_month),
    .o_day         (o_day),
    .o_hour        (o_hour),
    .o_minute      (o_minute),
    .o_second      (o_second),
    .o_osc_stopped (o_osc_stopped)
);

FILE: verif/bcd_rtc_time_check.sv
module bcd_rtc_time_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_raw_seconds,
    input  logic [7:0]  i_raw_minutes,
    input  logic [7:0]  i_raw_hours,
    input  logic [7:0]  i_raw_weekday,
    input  logic [7:0]  i_raw_date,
    input  logic [7:0]  i_raw_month,
    input  logic [7:0]  i_raw_year,
    input  logic [7:0]  i_status_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_time_valid,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    input  logic        i_osc_stopped,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    bcdrtc_pkg::t_res decoded_time_q [$];
    int               errors = 0;

    assign o_fail_count = errors;

    initial o_pending = 0;

    function automatic logic bcd_digits_ok(input logic [7:0] v);
        return (v[7:4] < 4'd10) && (v[3:0] < 4'd10);
    endfunction

    function automatic int unsigned bcd_to_int(input logic [7:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mo);
        int unsigned common_year [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (mo == 2 && ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0))
            return 29;
        return common_year[mo - 1];
    endfunction

    function automatic bcdrtc_pkg::t_res decode_rtc_snapshot(
        input logic [7:0] sec_b, min_b, hrs_b, wday_b, date_b, mon_b, yr_b, stat_b
    );
        bcdrtc_pkg::t_res r;
        logic [7:0]       s_f, m_f, h_f, d_f, mo_f;
        int unsigned      sec, mnt, hr, dy, mo, yr, mlen;
        r             = '0;
        r.osc_stopped = stat_b[7];
        s_f           = {1'b0, sec_b[6:0]};
        m_f           = {1'b0, min_b[6:0]};
        h_f           = {2'b00, hrs_b[5:0]};
        d_f           = {2'b00, date_b[5:0]};
        mo_f          = {3'b000, mon_b[4:0]};
        // mode bits first, then every bcd digit
        if ((hrs_b & bcdrtc_pkg::HourModeMask) != 8'h00 ||
            (mon_b & bcdrtc_pkg::CenturyMask) != 8'h00)
            return r;
        if (!(bcd_digits_ok(s_f) && bcd_digits_ok(m_f) && bcd_digits_ok(h_f) &&
              bcd_digits_ok(d_f) && bcd_digits_ok(mo_f) && bcd_digits_ok(yr_b)))
            return r;
        sec  = bcd_to_int(s_f);
        mnt  = bcd_to_int(m_f);
        hr   = bcd_to_int(h_f);
        dy   = bcd_to_int(d_f);
        mo   = bcd_to_int(mo_f);
        yr   = bcdrtc_pkg::BaseYear + bcd_to_int(yr_b);
        mlen = (mo >= 1 && mo <= bcdrtc_pkg::MaxMonth) ? days_in_month(yr, mo) : 0;
        if (sec > bcdrtc_pkg::MaxSecond || mnt > bcdrtc_pkg::MaxMinute ||
            hr > bcdrtc_pkg::MaxHour || wday_b[2:0] == 3'd0 ||
            mlen == 0 || dy < 1 || dy > mlen)
            return r;
        r.time_valid = 1'b1;
        r.year       = 12'(yr);
        r.month      = 4'(mo);
        r.day        = 5'(dy);
        r.hour       = 5'(hr);
        r.minute     = 6'(mnt);
        r.second     = 6'(sec);
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0d ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        bcdrtc_pkg::t_res got;
        bcdrtc_pkg::t_res want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                got = {i_time_valid, i_year, i_month, i_day, i_hour, i_minute, i_second,
                       i_osc_stopped};
                if (decoded_time_q.size() == 0) begin
                    errors++;
                    $display("%0d ns: result with no item outstanding, expected none, got %p",
                             $time, got);
                end else begin
                    want = decoded_time_q.pop_front();
                    compare_field("time_valid", want.time_valid, got.time_valid);
                    compare_field("year", want.year, got.year);
                    compare_field("month", want.month, got.month);
                    compare_field("day", want.day, got.day);
                    compare_field("hour", want.hour, got.hour);
                    compare_field("minute", want.minute, got.minute);
                    compare_field("second", want.second, got.second);
                    compare_field("osc_stopped", want.osc_stopped, got.osc_stopped);
                end
            end
            if (i_in_valid && i_in_ready)
                decoded_time_q.push_back(decode_rtc_snapshot(
                    i_raw_seconds, i_raw_minutes, i_raw_hours, i_raw_weekday,
                    i_raw_date, i_raw_month, i_raw_year, i_status_byte));
        end
        o_pending <= decoded_time_q.size();
    end

endmodule

FILE: verif/bcd_rtc_time_validate_decode_tb.sv
module bcd_rtc_time_validate_decode_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // byte positions within one register snapshot
    localparam int unsigned SecByte  = 0;
    localparam int unsigned MinByte  = 1;
    localparam int unsigned HourByte = 2;
    localparam int unsigned WdayByte = 3;
    localparam int unsigned DateByte = 4;
    localparam int unsigned MonByte  = 5;
    localparam int unsigned YearByte = 6;
    localparam int unsigned StatByte = 7;

    localparam int unsigned RandomPerPhase = 460;
    // watchdog limit on the whole run, well above what the slowest correct run needs
    localparam int unsigned CycleLimit     = 200000;

    typedef logic [7:0] t_snapshot [8];

    logic        i_clk;
    logic        i_rst_n;
    logic        snap_valid;
    logic        snap_ready;
    logic [7:0]  raw_seconds;
    logic [7:0]  raw_minutes;
    logic [7:0]  raw_hours;
    logic [7:0]  raw_weekday;
    logic [7:0]  raw_date;
    logic [7:0]  raw_month;
    logic [7:0]  raw_year;
    logic [7:0]  status_byte;
    logic        res_valid;
    logic        res_ready;
    logic        time_valid;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        osc_stopped;
    int          fail_count;
    int          pending;

    // idle odds in percent, changed between phases
    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 80;
    int unsigned cycle_count   = 0;

    bcd_rtc_time_validate_decode u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (snap_valid),
        .o_ready        (snap_ready),
        .i_raw_seconds  (raw_seconds),
        .i_raw_minutes  (raw_minutes),
        .i_raw_hours    (raw_hours),
        .i_raw_weekday  (raw_weekday),
        .i_raw_date     (raw_date),
        .i_raw_month    (raw_month),
        .i_raw_year     (raw_year),
        .i_status_byte  (status_byte),
        .o_valid        (res_valid),
        .i_ready        (res_ready),
        .o_time_valid   (time_valid),
        .o_year         (year),
        .o_month        (month),
        .o_day          (day),
        .o_hour         (hour),
        .o_minute       (minute),
        .o_second       (second),
        .o_osc_stopped  (osc_stopped)
    );

    bcd_rtc_time_check u_time_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (snap_valid),
        .i_in_ready     (snap_ready),
        .i_raw_seconds  (raw_seconds),
        .i_raw_minutes  (raw_minutes),
        .i_raw_hours    (raw_hours),
        .i_raw_weekday  (raw_weekday),
        .i_raw_date     (raw_date),
        .i_raw_month    (raw_month),
        .i_raw_year     (raw_year),
        .i_status_byte  (status_byte),
        .i_out_valid    (res_valid),
        .i_out_ready    (res_ready),
        .i_time_valid   (time_valid),
        .i_year         (year),
        .i_month        (month),
        .i_day          (day),
        .i_hour         (hour),
        .i_minute       (minute),
        .i_second       (second),
        .i_osc_stopped  (osc_stopped),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side stalls at random, odds set by the current phase
    always @(posedge i_clk) begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // mostly well-formed snapshots with random content and random don't-care bits,
    // the rest broken in one place or pure noise
    function automatic t_snapshot random_snapshot();
        t_snapshot   s;
        logic [7:0]  t;
        int unsigned pick;
        int unsigned digit_fields [6] = '{SecByte, MinByte, HourByte, DateByte, MonByte,
                                          YearByte};
        t           = to_bcd($urandom_range(59));
        s[SecByte]  = {1'($urandom), t[6:0]};
        t           = to_bcd($urandom_range(59));
        s[MinByte]  = {1'($urandom), t[6:0]};
        t           = to_bcd($urandom_range(23));
        s[HourByte] = {1'($urandom), 1'b0, t[5:0]};
        s[WdayByte] = {5'($urandom), 3'($urandom_range(7, 1))};
        // days 28 to 31 often, so month ends and leap years get hit
        t           = to_bcd(($urandom_range(2) == 0) ? $urandom_range(31, 28)
                                                      : $urandom_range(28, 1));
        s[DateByte] = {2'($urandom), t[5:0]};
        t           = to_bcd($urandom_range(12, 1));
        s[MonByte]  = {1'b0, 2'($urandom), t[4:0]};
        s[YearByte] = to_bcd($urandom_range(99));
        s[StatByte] = 8'($urandom);

        pick = $urandom_range(99);
        if (pick < 10) begin
            foreach (s[i]) s[i] = 8'($urandom);
        end else if (pick < 35) begin
            case ($urandom_range(9))
                0: s[HourByte][6] = 1'b1;   // twelve-hour mode
                1: s[MonByte][7] = 1'b1;    // century bit
                2: s[digit_fields[$urandom_range(5)]][3:0] = 4'($urandom_range(15, 10));
                3: s[YearByte][7:4] = 4'($urandom_range(15, 10));
                4: s[WdayByte][2:0] = 3'd0;
                5: s[SecByte][6:4] = 3'($urandom_range(7, 6));
                6: s[MinByte][6:4] = 3'($urandom_range(7, 6));
                7: begin
                    t = to_bcd($urandom_range(39, 24));
                    s[HourByte][5:0] = t[5:0];
                end
                8: begin
                    t = to_bcd(($urandom_range(1) == 0) ? 0 : $urandom_range(19, 13));
                    s[MonByte][4:0] = t[4:0];
                end
                default: begin
                    t = to_bcd(($urandom_range(1) == 0) ? 0 : $urandom_range(39, 32));
                    s[DateByte][5:0] = t[5:0];
                end
            endcase
        end
        return s;
    endfunction

    // present one snapshot, with a random gap ahead of it, and hold until accepted
    task automatic send_snapshot(input t_snapshot s);
        while ($urandom_range(99) < send_idle_pct) begin
            snap_valid <= 1'b0;
            @(posedge i_clk);
        end
        snap_valid  <= 1'b1;
        raw_seconds <= s[SecByte];
        raw_minutes <= s[MinByte];
        raw_hours   <= s[HourByte];
        raw_weekday <= s[WdayByte];
        raw_date    <= s[DateByte];
        raw_month   <= s[MonByte];
        raw_year    <= s[YearByte];
        status_byte <= s[StatByte];
        do @(posedge i_clk); while (!snap_ready);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        snap_valid  <= 1'b0;
        raw_seconds <= 8'h00;
        raw_minutes <= 8'h00;
        raw_hours   <= 8'h00;
        raw_weekday <= 8'h00;
        raw_date    <= 8'h00;
        raw_month   <= 8'h00;
        raw_year    <= 8'h00;
        status_byte <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: order is sec, min, hour, weekday, date, month, year, status
        // all zero, weekday/month/day all missing
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        // earliest valid time
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00});
        // latest valid time, every don't-care bit set, oscillator stopped
        send_snapshot('{8'hD9, 8'hD9, 8'hA3, 8'hFF, 8'hF1, 8'h72, 8'h99, 8'hFF});
        // twelve-hour mode
        send_snapshot('{8'h30, 8'h45, 8'h52, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00});
        // century bit
        send_snapshot('{8'h30, 8'h45, 8'h12, 8'h03, 8'h15, 8'h86, 8'h24, 8'h80});
        // bad bcd digits in seconds, year tens, minutes, date, hours
        send_snapshot('{8'h0A, 8'h45, 8'h12, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00});
        send_snapshot('{8'h30, 8'h45, 8'h12, 8'h03, 8'h15, 8'h06, 8'hA5, 8'h00});
        send_snapshot('{8'h30, 8'h1F, 8'h12, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00});
        send_snapshot('{8'h30, 8'h45, 8'h12, 8'h03, 8'h1C, 8'h06, 8'h24, 8'h80});
        send_snapshot('{8'h30, 8'h45, 8'h0E, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00});
        // weekday zero with upper bits set
        send_snapshot('{8'h30, 8'h45, 8'h12, 8'hF8, 8'h15, 8'h06, 8'h24, 8'h00});
        // out of range: second 60, minute 60, hour 24, month 0 and 13, day 0
        send_snapshot('{8'h60, 8'h45, 8'h12, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00});
        send_snapshot('{8'h30, 8'h60, 8'h12, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00});
        send_snapshot('{8'h30, 8'h45, 8'h24, 8'h03, 8'h15, 8'h06, 8'h24, 8'h00});
        send_snapshot('{8'h30, 8'h45, 8'h12, 8'h03, 8'h15, 8'h00, 8'h24, 8'h00});
        send_snapshot('{8'h30, 8'h45, 8'h12, 8'h03, 8'h15, 8'h13, 8'h24, 8'h00});
        send_snapshot('{8'h30, 8'h45, 8'h12, 8'h03, 8'h00, 8'h06, 8'h24, 8'h00});
        // day past month end: jan 32, apr 31
        send_snapshot('{8'h30, 8'h45, 8'h12, 8'h03, 8'h32, 8'h01, 8'h24, 8'h00});
        send_snapshot('{8'h30, 8'h45, 8'h12, 8'h03, 8'h31, 8'h04, 8'h24, 8'h00});
        // leap rule: feb 29 in 2000 and 2004 ok, 2001 not; feb 28 2001 ok; feb 30 never
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h02, 8'h29, 8'h02, 8'h00, 8'h00});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h02, 8'h29, 8'h02, 8'h04, 8'h00});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h02, 8'h29, 8'h02, 8'h01, 8'h00});
        send_snapshot('{8'h59, 8'h59, 8'h23, 8'h02, 8'h28, 8'h02, 8'h01, 8'h00});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h02, 8'h30, 8'h02, 8'h00, 8'h00});
        // every byte all ones
        send_snapshot('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});

        // random, sender mostly busy, receiver mostly stalled
        repeat (RandomPerPhase) send_snapshot(random_snapshot());
        // the other way round
        send_idle_pct = 80;
        recv_idle_pct = 18;
        repeat (RandomPerPhase) send_snapshot(random_snapshot());
        // both sides at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RandomPerPhase) send_snapshot(random_snapshot());

        // drain: let the count include the last item, then wait it out
        snap_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
